FILE: rtl/crcbse_pkg.sv
`default_nettype none

package crcbse_pkg;

  localparam int MAX_DEGREE = 32;
  localparam int DEG_W      = 6;
  localparam int POS_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int GEN_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = CFG_IDX_W'(1);

  typedef struct packed {
    logic message_bit;
    logic final_bit;
  } in_item_t;

  typedef struct packed {
    logic code_bit;
    logic is_check;
    logic run_end;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic clear;
    logic load_chk;
    logic shift_chk;
    logic fb;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/crcbse_if.sv
`default_nettype none

interface crcbse_in_if;
  import crcbse_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crcbse_out_if;
  import crcbse_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/crcbse_cell.sv
`default_nettype none

module crcbse_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  crcbse_pkg::cell_ctrl_t  ctrl,
  input  logic                    active,
  input  logic                    gen_bit,
  input  logic                    rem_prev,
  input  logic                    chk_prev,
  output logic                    rem,
  output logic                    chk
);
  import crcbse_pkg::*;

  logic step_val;

  // Cells at or above the degree read as zero once a bit is shifted in
  assign step_val = active & (rem_prev ^ (ctrl.fb & gen_bit));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 1'b0;
    end else if (ctrl.step) begin
      rem <= ctrl.clear ? 1'b0 : step_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_chk) begin
      chk <= step_val;
    end else if (ctrl.shift_chk) begin
      chk <= chk_prev;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crc_bit_serial_encoder_top.sv
`default_nettype none
// A code bit is captured in the output register in the cycle after its message bit transfers.
// Throughput: one message bit per cycle unless the output stalls; the final bit is followed by
// degree check bits, one per cycle unless stalled, from the check row while input is held off.
// Reset (synchronous, active high) clears the remainder, the output valid and the check count,
// and sets the generator low terms to 7 and the degree to 8.
module crc_bit_serial_encoder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crcbse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crcbse_pkg::CFG_DATA_W-1:0]   cfg_data,
  crcbse_in_if.sink                           msg,
  crcbse_out_if.source                        code
);
  import crcbse_pkg::*;

  logic [GEN_W-1:0]      gen;
  logic [DEG_W-1:0]      degree;
  logic [DEG_W-1:0]      eff_deg;
  logic [POS_W-1:0]      top_pos;
  logic [MAX_DEGREE-1:0] rem;
  logic [MAX_DEGREE-1:0] chk;
  logic [DEG_W-1:0]      drain_cnt;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  out_free;
  logic                  busy;
  logic                  in_xfer;
  logic                  drain_go;
  cell_ctrl_t            ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen    <= GEN_W'(7);
      degree <= DEG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GENERATOR: gen    <= cfg_data[GEN_W-1:0];
        REG_DEGREE:    degree <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (degree == '0) begin
      eff_deg = DEG_W'(1);
    end else if (degree > DEG_W'(MAX_DEGREE)) begin
      eff_deg = DEG_W'(MAX_DEGREE);
    end else begin
      eff_deg = degree;
    end
  end

  assign top_pos = POS_W'(eff_deg - DEG_W'(1));

  assign out_free  = !out_valid || code.ready;
  assign busy      = (drain_cnt != '0);
  assign msg.ready = out_free && !busy;
  assign in_xfer   = msg.valid && msg.ready;
  assign drain_go  = busy && out_free;

  assign ctrl.step      = in_xfer;
  assign ctrl.clear     = in_xfer && msg.data.final_bit;
  assign ctrl.load_chk  = in_xfer && msg.data.final_bit;
  assign ctrl.shift_chk = drain_go;
  assign ctrl.fb        = rem[top_pos] ^ msg.data.message_bit;

  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
    logic rem_prev;
    logic chk_prev;
    logic gen_bit;

    if (i == 0) begin : g_head
      assign rem_prev = 1'b0;
      assign chk_prev = 1'b0;
    end else begin : g_body
      assign rem_prev = rem[i-1];
      assign chk_prev = chk[i-1];
    end

    if (i < GEN_W) begin : g_gen
      assign gen_bit = gen[i];
    end else begin : g_nogen
      assign gen_bit = 1'b0;
    end

    crcbse_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .active   (eff_deg > DEG_W'(i)),
      .gen_bit  (gen_bit),
      .rem_prev (rem_prev),
      .chk_prev (chk_prev),
      .rem      (rem[i]),
      .chk      (chk[i])
    );
  end

  // Count check bits still to send; a final bit loads the effective degree
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_cnt <= '0;
    end else if (ctrl.load_chk) begin
      drain_cnt <= eff_deg;
    end else if (drain_go) begin
      drain_cnt <= drain_cnt - DEG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer || drain_go) begin
      out_valid <= 1'b1;
    end else if (code.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_item <= '{code_bit: msg.data.message_bit, is_check: 1'b0, run_end: 1'b0};
    end else if (drain_go) begin
      out_item <= '{code_bit: chk[top_pos], is_check: 1'b1,
                    run_end: (drain_cnt == DEG_W'(1))};
    end
  end

  assign code.valid = out_valid;
  assign code.data  = out_item;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import crcbse_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int unsigned LONG_HOLD = 300;

  typedef enum logic {ROW_WRITE, ROW_BIT} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    val;
    in_item_t                 bit_in;
    bit                       typed;
    logic [GEN_W-1:0]         chk;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crcbse_in_if  msg_if ();
  crcbse_out_if code_if ();

  crc_bit_serial_encoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg       (msg_if),
    .code      (code_if)
  );

  // local copy of the encoder state and registers
  logic [GEN_W-1:0] gen_terms;
  logic [DEG_W-1:0] degree_reg;
  logic [GEN_W-1:0] crc_rem;

  out_item_t   code_bits_due[$];
  stim_row_t   stim_rows[$];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned n_errors;
  int unsigned n_msg_bits;
  int unsigned n_messages;
  int unsigned n_code_bits;
  int unsigned n_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("tb: done, errors");
    $finish;
  end

  // one bit of GF(2) division; on the final bit, queue the remainder (or the given check word) as check bits
  function automatic void divide_bit(input in_item_t it, input bit typed,
                                     input logic [GEN_W-1:0] typed_chk);
    int unsigned      d;
    logic [63:0]      mask;
    logic [GEN_W-1:0] chk;
    logic             fb;
    out_item_t        ob;
    d = degree_reg;
    if (d < 1) d = 1;
    if (d > MAX_DEGREE) d = MAX_DEGREE;
    mask = (64'd1 << d) - 64'd1;
    crc_rem = crc_rem & mask[GEN_W-1:0];
    fb = crc_rem[d-1] ^ it.message_bit;
    crc_rem = (crc_rem << 1) & mask[GEN_W-1:0];
    if (fb) crc_rem = crc_rem ^ (gen_terms & mask[GEN_W-1:0]);
    ob.code_bit = it.message_bit;
    ob.is_check = 1'b0;
    ob.run_end  = 1'b0;
    code_bits_due = {code_bits_due, ob};
    if (it.final_bit) begin
      chk = typed ? typed_chk : crc_rem;
      for (int unsigned k = 0; k < d; k++) begin
        ob.code_bit = chk[d-1-k];
        ob.is_check = 1'b1;
        ob.run_end  = (k == d - 1);
        code_bits_due = {code_bits_due, ob};
      end
      crc_rem = '0;
      n_messages++;
    end
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r.kind   = ROW_WRITE;
    r.idx    = idx;
    r.val    = val;
    r.bit_in = '0;
    r.typed  = 1'b0;
    r.chk    = '0;
    stim_rows = {stim_rows, r};
  endfunction

  function automatic void add_bit(input logic m, input logic f);
    stim_row_t r;
    r.kind               = ROW_BIT;
    r.idx                = '0;
    r.val                = '0;
    r.bit_in.message_bit = m;
    r.bit_in.final_bit   = f;
    r.typed              = 1'b0;
    r.chk                = '0;
    stim_rows = {stim_rows, r};
  endfunction

  // final bit whose check word is known up front
  function automatic void add_final_chk(input logic m, input logic [GEN_W-1:0] chk);
    add_bit(m, 1'b1);
    stim_rows[$].typed = 1'b1;
    stim_rows[$].chk   = chk;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    msg_if.valid <= 1'b0;
    while (code_bits_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GENERATOR) gen_terms = val[GEN_W-1:0];
    else if (idx == REG_DEGREE) degree_reg = val[DEG_W-1:0];
    n_writes++;
  endtask

  // leaves valid high after the transfer; the next call either idles or replaces the data
  task automatic send_bit(input in_item_t it, input bit typed, input logic [GEN_W-1:0] chk);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(posedge clk);
    end
    msg_if.valid <= 1'b1;
    msg_if.data  <= it;
    do @(posedge clk); while (!msg_if.ready);
    divide_bit(it, typed, chk);
    n_msg_bits++;
  endtask

  task automatic run_messages(input int unsigned n_bits);
    int unsigned sent;
    int unsigned len;
    in_item_t    it;
    sent = 0;
    while (sent < n_bits) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(12, 1);
      // trim the last message so the phase sends exactly n_bits
      if (len > n_bits - sent) len = n_bits - sent;
      for (int unsigned j = 0; j < len; j++) begin
        it.message_bit = $urandom_range(1);
        it.final_bit   = (j == len - 1);
        send_bit(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver: check every transfer, then pick ready for the next edge
  initial begin
    int unsigned hold_left;
    out_item_t   want;
    out_item_t   got;
    hold_left = 0;
    code_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && code_if.valid && code_if.ready) begin
        got = code_if.data;
        n_code_bits++;
        if (code_bits_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 50)
            $display("%0t: code bit with none pending, got %b/%b/%b", $time,
                     got.code_bit, got.is_check, got.run_end);
        end else begin
          want = code_bits_due.pop_front();
          if (got.code_bit !== want.code_bit || got.is_check !== want.is_check ||
              got.run_end !== want.run_end) begin
            n_errors++;
            if (n_errors <= 50)
              $display("%0t: mismatch code/check/end expected %b/%b/%b actual %b/%b/%b",
                       $time, want.code_bit, want.is_check, want.run_end,
                       got.code_bit, got.is_check, got.run_end);
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        code_if.ready <= 1'b0;
      end else begin
        code_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    gen_terms     = GEN_W'(7);
    degree_reg    = DEG_W'(8);
    crc_rem       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    n_errors      = 0;
    n_msg_bits    = 0;
    n_messages    = 0;
    n_code_bits   = 0;
    n_writes      = 0;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    msg_if.valid <= 1'b0;
    msg_if.data  <= '0;

    // reset generator x^8+x^2+x+1
    add_final_chk(1'b0, 32'h0000_0000);
    add_final_chk(1'b1, 32'h0000_0007);
    add_bit(1'b1, 1'b0);
    add_final_chk(1'b1, 32'h0000_0009);
    // parity: x+1
    add_write(REG_DEGREE, 32'd1);
    add_write(REG_GENERATOR, 32'd1);
    add_final_chk(1'b1, 32'h0000_0001);
    add_final_chk(1'b0, 32'h0000_0000);
    // degree zero acts as one; only the low generator bit counts
    add_write(REG_DEGREE, 32'd0);
    add_write(REG_GENERATOR, 32'hFFFF_FFFF);
    add_final_chk(1'b1, 32'h0000_0001);
    // degree above the maximum clamps to 32
    add_write(REG_DEGREE, 32'd63);
    add_final_chk(1'b1, 32'hFFFF_FFFF);
    add_write(REG_DEGREE, 32'd33);
    add_write(REG_GENERATOR, 32'h04C1_1DB7);
    add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b0);
    add_bit(1'b1, 1'b0);
    add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b0);
    add_bit(1'b0, 1'b0);
    add_bit(1'b1, 1'b0);
    add_bit(1'b1, 1'b1);
    // bits above the degree field are dropped
    add_write(REG_GENERATOR, 32'h0000_0003);
    add_write(REG_DEGREE, 32'hFFFF_FFC4);
    add_final_chk(1'b1, 32'h0000_0003);
    // change the degree and generator partway through a message; unused indexes do nothing
    add_bit(1'b1, 1'b0);
    add_bit(1'b1, 1'b0);
    add_write(REG_DEGREE, 32'd8);
    add_write(REG_GENERATOR, 32'h0000_0007);
    add_write(REG_SPARE_A, 32'h0000_005A);
    add_write(REG_SPARE_B, 32'hFFFF_FFFF);
    add_bit(1'b0, 1'b0);
    add_bit(1'b1, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE)
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      else
        send_bit(stim_rows[i].bit_in, stim_rows[i].typed, stim_rows[i].chk);
    end

    // no idling, with a long receiver hold-off to back up the input
    write_reg(REG_DEGREE, 32'd16);
    write_reg(REG_GENERATOR, 32'h0000_1021);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    run_messages(28);

    write_reg(REG_DEGREE, 32'd32);
    write_reg(REG_GENERATOR, 32'h04C1_1DB7);
    send_idle_pct = 70;
    stall_pct     = 0;
    run_messages(28);

    write_reg(REG_DEGREE, 32'd1);
    write_reg(REG_GENERATOR, $urandom);
    send_idle_pct = 0;
    stall_pct     = 70;
    run_messages(28);

    write_reg(REG_DEGREE, $urandom_range(63, 33));
    write_reg(REG_GENERATOR, $urandom);
    send_idle_pct = 11;
    stall_pct     = 11;
    run_messages(28);

    write_reg(REG_DEGREE, $urandom_range(63));
    write_reg(REG_GENERATOR, $urandom);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_messages(28);

    msg_if.valid <= 1'b0;
    while (code_bits_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("tb: %0d message bits in %0d messages, %0d code bits checked",
             n_msg_bits, n_messages, n_code_bits);
    $display("tb: %0d register writes, degrees 0 to 63, four idle/stall mixes, one long hold",
             n_writes);
    if (n_errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
